### design/epws_pkg.sv
// Shared types and constants for the paged EEPROM write sequencer.
package epws_pkg;

    localparam int ADDR_W = 16;
    localparam int LEN_W  = 16;
    localparam int PORT_W = 3;
    localparam int TIME_W = 32;

    localparam int          PAGE_SIZE_DEF = 16;
    localparam logic [31:0] TIMEOUT_RESET = 32'd5;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_START = 2'd1,
        PH_WAIT  = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        ST_BUSY    = 2'd0,
        ST_SUCCESS = 2'd1,
        ST_ERROR   = 2'd2
    } t_status;

    typedef struct packed {
        t_status             status;
        logic                send;
        logic [ADDR_W-1:0]   page_address;
        logic [LEN_W-1:0]    page_length;
        logic [LEN_W-1:0]    buffer_offset;
        logic [PORT_W-1:0]   port_out;
    } t_result;

endpackage

### design/epws_core.sv
// Write sequencer state and per-request page split logic.
module epws_core #(
    parameter int PAGE_SIZE = epws_pkg::PAGE_SIZE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic [epws_pkg::ADDR_W-1:0]   i_addr,
    input  logic [epws_pkg::ADDR_W-1:0]   i_quot,
    input  logic [epws_pkg::LEN_W-1:0]    i_len,
    input  logic [epws_pkg::PORT_W-1:0]   i_port,
    input  logic [epws_pkg::TIME_W-1:0]   i_now,
    input  logic [epws_pkg::TIME_W-1:0]   i_timeout,
    output epws_pkg::t_result             o_result
);

    localparam int OFF_W = (PAGE_SIZE > 1) ? $clog2(PAGE_SIZE) : 1;
    localparam int QP_W  = epws_pkg::ADDR_W + 9;
    localparam int SPAN  = 1 << epws_pkg::ADDR_W;
    localparam logic [OFF_W-1:0] WRAP_OFF =
        OFF_W'((PAGE_SIZE - (SPAN % PAGE_SIZE)) % PAGE_SIZE);
    localparam logic [epws_pkg::ADDR_W:0] PAGE_EXT = (epws_pkg::ADDR_W + 1)'(PAGE_SIZE);

    epws_pkg::t_phase            r_phase, n_phase;
    logic [epws_pkg::ADDR_W-1:0] r_next_addr, n_next_addr;
    logic [epws_pkg::LEN_W-1:0]  r_left, n_left;
    logic [epws_pkg::LEN_W-1:0]  r_sent, n_sent;
    logic [OFF_W-1:0]            r_page_off, n_page_off;
    logic [epws_pkg::TIME_W-1:0] r_stamp, n_stamp;

    logic [QP_W-1:0]             w_qp;
    logic [OFF_W-1:0]            w_in_off;
    logic                        w_idle;
    epws_pkg::t_phase            w_eff_phase;
    logic [epws_pkg::ADDR_W-1:0] w_eff_addr;
    logic [epws_pkg::LEN_W-1:0]  w_eff_left;
    logic [epws_pkg::LEN_W-1:0]  w_eff_sent;
    logic [OFF_W-1:0]            w_eff_off;
    logic                        w_fits;
    logic [epws_pkg::LEN_W-1:0]  w_size;
    logic [epws_pkg::ADDR_W:0]   w_addr_sum;
    logic [epws_pkg::TIME_W-1:0] w_elapsed;
    logic                        w_expired;
    logic                        w_have_left;

    // In-page offset of the start address from the registered quotient.
    assign w_qp     = QP_W'(i_quot) * QP_W'(PAGE_SIZE);
    assign w_in_off = OFF_W'(i_addr - epws_pkg::ADDR_W'(w_qp));

    // An idle request latches its write and proceeds as a start request.
    assign w_idle      = (r_phase == epws_pkg::PH_IDLE);
    assign w_eff_phase = w_idle ? epws_pkg::PH_START : r_phase;
    assign w_eff_addr  = w_idle ? i_addr   : r_next_addr;
    assign w_eff_left  = w_idle ? i_len    : r_left;
    assign w_eff_sent  = w_idle ? '0       : r_sent;
    assign w_eff_off   = w_idle ? w_in_off : r_page_off;
    assign w_have_left = (w_eff_left != '0);

    assign w_fits = ((epws_pkg::ADDR_W + 1)'(w_eff_left) + (epws_pkg::ADDR_W + 1)'(w_eff_off))
                    < PAGE_EXT;
    assign w_size = w_fits ? w_eff_left
                           : epws_pkg::LEN_W'(PAGE_EXT - (epws_pkg::ADDR_W + 1)'(w_eff_off));
    assign w_addr_sum = (epws_pkg::ADDR_W + 1)'(w_eff_addr) + (epws_pkg::ADDR_W + 1)'(w_size);

    assign w_elapsed = i_now - r_stamp;
    assign w_expired = (w_elapsed >= i_timeout);

    // Next phase.
    always_comb begin
        case (w_eff_phase)
            epws_pkg::PH_START: begin
                n_phase = w_have_left ? epws_pkg::PH_WAIT : epws_pkg::PH_IDLE;
            end
            epws_pkg::PH_WAIT: begin
                if (!w_expired) begin
                    n_phase = epws_pkg::PH_WAIT;
                end else if (w_have_left) begin
                    n_phase = epws_pkg::PH_START;
                end else begin
                    n_phase = epws_pkg::PH_IDLE;
                end
            end
            default: begin
                n_phase = epws_pkg::PH_IDLE;
            end
        endcase
    end

    // Result and datapath state.
    always_comb begin
        o_result    = '0;
        n_next_addr = w_eff_addr;
        n_left      = w_eff_left;
        n_sent      = w_eff_sent;
        n_page_off  = w_eff_off;
        n_stamp     = r_stamp;
        case (w_eff_phase)
            epws_pkg::PH_START: begin
                if (w_have_left) begin
                    o_result.status        = epws_pkg::ST_BUSY;
                    o_result.send          = 1'b1;
                    o_result.page_address  = w_eff_addr;
                    o_result.page_length   = w_size;
                    o_result.buffer_offset = w_eff_sent;
                    o_result.port_out      = i_port;
                    n_left      = w_eff_left - w_size;
                    n_next_addr = epws_pkg::ADDR_W'(w_addr_sum);
                    n_sent      = w_eff_sent + w_size;
                    // a split chunk ends on a page boundary, unless the address wrapped
                    n_page_off  = w_addr_sum[epws_pkg::ADDR_W] ? WRAP_OFF : '0;
                    n_stamp     = i_now;
                end else begin
                    o_result.status = epws_pkg::ST_ERROR;
                end
            end
            epws_pkg::PH_WAIT: begin
                if (w_expired && !w_have_left) begin
                    o_result.status = epws_pkg::ST_SUCCESS;
                end else begin
                    o_result.status = epws_pkg::ST_BUSY;
                end
            end
            default: begin
                o_result.status = epws_pkg::ST_ERROR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= epws_pkg::PH_IDLE;
            r_next_addr <= '0;
            r_left      <= '0;
            r_sent      <= '0;
            r_page_off  <= '0;
            r_stamp     <= '0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_next_addr <= n_next_addr;
            r_left      <= n_left;
            r_sent      <= n_sent;
            r_page_off  <= n_page_off;
            r_stamp     <= n_stamp;
        end
    end

    a_chunk_in_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_result.send) |->
        ((epws_pkg::ADDR_W + 1)'(w_eff_off) + (epws_pkg::ADDR_W + 1)'(w_size) <= PAGE_EXT))
        else $error("chunk crosses a page boundary");

    a_send_then_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_result.send) |=> (r_phase == epws_pkg::PH_WAIT))
        else $error("no wait phase after a page send");

endmodule

### design/eeprom_paged_write_sequencer.sv
// Top level of the paged EEPROM write sequencer: request and result stages.
// A request is registered in the request stage and its result in the result stage.
// Throughput: one request per cycle unless the output stalls; the page split, the
// elapsed-time compare and the state update sit between the request register and
// the result register. Reset (synchronous, active low) empties both stages,
// returns the sequencer to idle and sets the page write timeout to 5.
module eeprom_paged_write_sequencer #(
    parameter int PAGE_SIZE = epws_pkg::PAGE_SIZE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [epws_pkg::TIME_W-1:0]   i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [epws_pkg::ADDR_W-1:0]   i_start_address,
    input  logic [epws_pkg::LEN_W-1:0]    i_write_length,
    input  logic [epws_pkg::PORT_W-1:0]   i_bus_port,
    input  logic [epws_pkg::TIME_W-1:0]   i_now_time,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [1:0]                    o_status,
    output logic                          o_send_page,
    output logic [epws_pkg::ADDR_W-1:0]   o_page_address,
    output logic [epws_pkg::LEN_W-1:0]    o_page_length,
    output logic [epws_pkg::LEN_W-1:0]    o_buffer_offset,
    output logic [epws_pkg::PORT_W-1:0]   o_port_out
);

    // Exact floor division of a 16-bit address by the page size.
    localparam int   LOG_P   = (PAGE_SIZE > 1) ? $clog2(PAGE_SIZE) : 0;
    localparam int   Q_SHIFT = epws_pkg::ADDR_W + LOG_P;
    localparam int   RCP_W   = epws_pkg::ADDR_W + 1;
    localparam int   PROD_W  = epws_pkg::ADDR_W + RCP_W;
    localparam longint RCP_VAL = ((longint'(1) << Q_SHIFT) + PAGE_SIZE - 1) / PAGE_SIZE;
    localparam logic [RCP_W-1:0] RECIP = RCP_W'(RCP_VAL);

    logic [epws_pkg::TIME_W-1:0] r_timeout;

    logic                        r_in_vld;
    logic [epws_pkg::ADDR_W-1:0] r_addr;
    logic [epws_pkg::ADDR_W-1:0] r_quot;
    logic [epws_pkg::LEN_W-1:0]  r_len;
    logic [epws_pkg::PORT_W-1:0] r_port;
    logic [epws_pkg::TIME_W-1:0] r_now;

    logic                        r_out_vld;
    epws_pkg::t_result           r_res;

    logic                        w_adv;
    logic                        w_in_take;
    logic [PROD_W-1:0]           w_prod;
    epws_pkg::t_result           w_res;

    assign o_cfg_ready = 1'b1;

    assign w_adv      = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || w_adv;
    assign w_in_take  = i_in_valid && o_in_ready;

    assign w_prod = PROD_W'(i_start_address) * PROD_W'(RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= epws_pkg::TIMEOUT_RESET;
        end else if (i_cfg_valid) begin
            r_timeout <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_in_take) begin
            r_in_vld <= 1'b1;
        end else if (w_adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_addr <= i_start_address;
            r_quot <= epws_pkg::ADDR_W'(w_prod >> Q_SHIFT);
            r_len  <= i_write_length;
            r_port <= i_bus_port;
            r_now  <= i_now_time;
        end
    end

    epws_core #(
        .PAGE_SIZE (PAGE_SIZE)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_adv),
        .i_addr    (r_addr),
        .i_quot    (r_quot),
        .i_len     (r_len),
        .i_port    (r_port),
        .i_now     (r_now),
        .i_timeout (r_timeout),
        .o_result  (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_res <= w_res;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_status        = r_res.status;
    assign o_send_page     = r_res.send;
    assign o_page_address  = r_res.page_address;
    assign o_page_length   = r_res.page_length;
    assign o_buffer_offset = r_res.buffer_offset;
    assign o_port_out      = r_res.port_out;

    a_idle_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !o_send_page) |->
        (o_page_address == '0 && o_page_length == '0 && o_buffer_offset == '0 &&
         o_port_out == '0))
        else $error("chunk fields set without a page send");

    a_send_is_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && o_send_page) |->
        (o_status == epws_pkg::ST_BUSY && o_page_length != '0))
        else $error("page send with bad status or empty chunk");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_vld && r_out_vld && !i_out_ready))
        else $error("request stalled with room downstream");

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the paged EEPROM write sequencer.
module tb_top;

    localparam int PAGE_BYTES    = epws_pkg::PAGE_SIZE_DEF;
    localparam int SETTLE_CYCLES = 6;
    localparam int SQUEEZE_LEN   = 400;

    class chunk_predictor;
        epws_pkg::t_phase  phase;
        logic [15:0]       next_addr;
        logic [15:0]       bytes_left;
        logic [15:0]       bytes_done;
        logic [31:0]       stamp;
        logic [31:0]       timeout;
        epws_pkg::t_result queued_results[$];
        int                mismatches;
        int                strays;
        int                polls;
        int                chunks;
        int                completions;
        int                rejects;
        int                settings;

        function new();
            phase       = epws_pkg::PH_IDLE;
            next_addr   = '0;
            bytes_left  = '0;
            bytes_done  = '0;
            stamp       = '0;
            timeout     = epws_pkg::TIMEOUT_RESET;
            mismatches  = 0;
            strays      = 0;
            polls       = 0;
            chunks      = 0;
            completions = 0;
            rejects     = 0;
            settings    = 0;
        endfunction

        function void set_timeout(logic [31:0] value);
            timeout = value;
            settings++;
        endfunction

        // Advance the sequencer state by one poll and queue the result it gives.
        function void note_poll(logic [15:0] addr, logic [15:0] len, logic [2:0] port,
                                logic [31:0] now);
            epws_pkg::t_result r;
            int unsigned       cur_page;
            int unsigned       end_page;
            int unsigned       size;
            r = '0;
            r.status = epws_pkg::ST_ERROR;
            polls++;
            if (phase == epws_pkg::PH_IDLE) begin
                next_addr  = addr;
                bytes_left = len;
                bytes_done = '0;
                phase      = epws_pkg::PH_START;
            end
            if (phase == epws_pkg::PH_START) begin
                if (bytes_left != 0) begin
                    cur_page = 32'(next_addr) / PAGE_BYTES;
                    end_page = (32'(next_addr) + 32'(bytes_left)) / PAGE_BYTES;
                    // stop at the page boundary unless the rest fits in this page
                    size = (cur_page == end_page) ? 32'(bytes_left)
                                                  : (cur_page + 1) * PAGE_BYTES - 32'(next_addr);
                    r.status        = epws_pkg::ST_BUSY;
                    r.send          = 1'b1;
                    r.page_address  = next_addr;
                    r.page_length   = size[15:0];
                    r.buffer_offset = bytes_done;
                    r.port_out      = port;
                    bytes_left = bytes_left - size[15:0];
                    next_addr  = next_addr + size[15:0];
                    bytes_done = bytes_done + size[15:0];
                    stamp      = now;
                    phase      = epws_pkg::PH_WAIT;
                    chunks++;
                end else begin
                    phase = epws_pkg::PH_IDLE;
                    rejects++;
                end
            end else if (phase == epws_pkg::PH_WAIT) begin
                if (now - stamp < timeout) begin
                    r.status = epws_pkg::ST_BUSY;
                end else if (bytes_left != 0) begin
                    phase    = epws_pkg::PH_START;
                    r.status = epws_pkg::ST_BUSY;
                end else begin
                    phase    = epws_pkg::PH_IDLE;
                    r.status = epws_pkg::ST_SUCCESS;
                    completions++;
                end
            end else begin
                phase = epws_pkg::PH_IDLE;
            end
            queued_results.push_back(r);
        endfunction

        function void check_result(epws_pkg::t_result got);
            epws_pkg::t_result want;
            if (queued_results.size() == 0) begin
                if (mismatches + strays < 10)
                    $display("ERROR: result with no poll pending (status %0d send %0d)",
                             got.status, got.send);
                strays++;
                return;
            end
            want = queued_results.pop_front();
            if (got.status !== want.status || got.send !== want.send ||
                got.page_address !== want.page_address ||
                got.page_length !== want.page_length ||
                got.buffer_offset !== want.buffer_offset ||
                got.port_out !== want.port_out) begin
                if (mismatches + strays < 10) begin
                    $display("ERROR: expected status %0d send %0d addr %h len %0d off %0d port %0d",
                             want.status, want.send, want.page_address, want.page_length,
                             want.buffer_offset, want.port_out);
                    $display("       actual   status %0d send %0d addr %h len %0d off %0d port %0d",
                             got.status, got.send, got.page_address, got.page_length,
                             got.buffer_offset, got.port_out);
                end
                mismatches++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [15:0] i_start_address;
    logic [15:0] i_write_length;
    logic [2:0]  i_bus_port;
    logic [31:0] i_now_time;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [1:0]  o_status;
    logic        o_send_page;
    logic [15:0] o_page_address;
    logic [15:0] o_page_length;
    logic [15:0] o_buffer_offset;
    logic [2:0]  o_port_out;

    chunk_predictor board;
    bit             steady;
    bit             squeeze_go;

    eeprom_paged_write_sequencer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_start_address (i_start_address),
        .i_write_length  (i_write_length),
        .i_bus_port      (i_bus_port),
        .i_now_time      (i_now_time),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_send_page     (o_send_page),
        .o_page_address  (o_page_address),
        .o_page_length   (o_page_length),
        .o_buffer_offset (o_buffer_offset),
        .o_port_out      (o_port_out)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("ERROR: watchdog expired before the run finished");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic send_poll(input logic [15:0] addr, input logic [15:0] len,
                             input logic [2:0] port, input logic [31:0] now);
        if (!steady && $urandom_range(0, 99) < 34) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < 34);
        end
        i_in_valid      <= 1'b1;
        i_start_address <= addr;
        i_write_length  <= len;
        i_bus_port      <= port;
        i_now_time      <= now;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_poll(addr, len, port, now);
    endtask

    // Pick a poll that fits the current phase so that writes run to their end.
    task automatic poll_once();
        logic [15:0] addr;
        logic [15:0] len;
        logic [2:0]  port;
        logic [31:0] now;
        int          pick;
        addr = 16'($urandom);
        len  = 16'($urandom);
        port = 3'($urandom);
        now  = $urandom;
        pick = $urandom_range(0, 99);
        if (board.phase == epws_pkg::PH_IDLE) begin
            if (pick < 6)
                len = '0;
            else if (pick < 70)
                len = 16'($urandom_range(1, 40));
            else if (pick < 92)
                len = 16'($urandom_range(41, 300));
            else
                len = 16'($urandom_range(1, PAGE_BYTES));
            pick = $urandom_range(0, 99);
            if (pick < 20)
                addr = addr - 16'(addr % PAGE_BYTES);
            else if (pick < 40)
                addr = 16'hFFFF - 16'($urandom_range(0, 40));
        end else if (board.phase == epws_pkg::PH_WAIT) begin
            // aim most polls at the edge of the timeout window
            if (pick < 45)
                now = board.stamp + board.timeout + 32'($urandom_range(0, 2));
            else if (pick < 65)
                now = board.stamp + board.timeout - 32'd1;
            else if (pick < 85 && board.timeout != 0)
                now = board.stamp + $urandom % board.timeout;
        end
        send_poll(addr, len, port, now);
    endtask

    task automatic write_timeout(input logic [31:0] value);
        i_in_valid <= 1'b0;
        while (board.queued_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        board.set_timeout(value);
    endtask

    initial begin : result_sink
        epws_pkg::t_result got;
        int                hold_left;
        bit                squeezed;
        hold_left = 0;
        squeezed  = 1'b0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                got.status        = epws_pkg::t_status'(o_status);
                got.send          = o_send_page;
                got.page_address  = o_page_address;
                got.page_length   = o_page_length;
                got.buffer_offset = o_buffer_offset;
                got.port_out      = o_port_out;
                board.check_result(got);
            end
            if (squeeze_go && !squeezed) begin
                squeezed  = 1'b1;
                hold_left = SQUEEZE_LEN;
            end
            // hold off long enough for the block to back up into its input
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= steady || ($urandom_range(0, 99) >= 34);
            end
        end
    end

    initial begin : stimulus
        logic [31:0] phase_timeouts [6];
        int          drain_wait;
        int          k;
        int          n;
        board = new();
        steady     <= 1'b0;
        squeeze_go <= 1'b0;
        i_rst_n         <= 1'b0;
        i_cfg_valid     <= 1'b0;
        i_cfg_data      <= '0;
        i_in_valid      <= 1'b0;
        i_start_address <= '0;
        i_write_length  <= '0;
        i_bus_port      <= '0;
        i_now_time      <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero length, then a write split across a page, at the reset timeout
        send_poll(16'hFFFF, 16'h0000, 3'd7, 32'hFFFF_FFFF);
        send_poll(16'h0003, 16'd20, 3'd5, 32'd100);
        send_poll(16'h0000, 16'hFFFF, 3'd0, 32'd104);
        send_poll(16'hFFFF, 16'h0000, 3'd7, 32'd105);
        send_poll(16'h0000, 16'h0000, 3'd2, 32'd200);
        send_poll(16'h0000, 16'h0000, 3'd0, 32'd205);
        // top of the address space, with the time counter wrapping too
        send_poll(16'hFFFA, 16'd10, 3'd0, 32'hFFFF_FFFE);
        send_poll(16'h0000, 16'h0000, 3'd4, 32'd3);
        send_poll(16'h5555, 16'hAAAA, 3'd1, 32'd10);
        send_poll(16'h0000, 16'h0000, 3'd0, 32'd14);
        send_poll(16'h0000, 16'h0000, 3'd0, 32'd15);
        // exactly one page, page aligned
        send_poll(16'h0010, 16'd16, 3'd6, 32'd0);
        send_poll(16'h0000, 16'h0000, 3'd0, 32'd5);

        write_timeout(32'hFFFF_FFFF);
        send_poll(16'h0000, 16'h0001, 3'd1, 32'h8000_0000);
        send_poll(16'h1234, 16'h5678, 3'd6, 32'h7FFF_FFFE);
        send_poll(16'h0000, 16'h0000, 3'd0, 32'h7FFF_FFFF);

        write_timeout(32'd0);
        send_poll(16'h00F8, 16'd12, 3'd3, 32'd50);
        send_poll(16'h0000, 16'h0000, 3'd0, 32'd50);
        send_poll(16'h0000, 16'h0000, 3'd3, 32'd60);
        send_poll(16'h0000, 16'h0000, 3'd0, 32'd60);

        phase_timeouts = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'($urandom_range(2, 40)),
                           $urandom, 32'd5};
        for (k = 0; k < 6; k++) begin
            write_timeout(phase_timeouts[k]);
            steady <= (k == 2);
            for (n = 0; n < 180; n++) begin
                if (k == 0 && n == 20)
                    squeeze_go <= 1'b1;
                poll_once();
            end
        end

        // finish any open write, then one long multi-page write from the top of
        // the address space, run back to back
        write_timeout(32'd0);
        steady <= 1'b1;
        while (board.phase != epws_pkg::PH_IDLE) poll_once();
        send_poll(16'hFFFF, 16'h0201, 3'($urandom), $urandom);
        while (board.phase != epws_pkg::PH_IDLE) poll_once();
        steady <= 1'b0;
        send_poll(16'h0000, 16'h0000, 3'd0, 32'd0);

        i_in_valid <= 1'b0;
        drain_wait = 0;
        while (board.queued_results.size() != 0 && drain_wait < 20000) begin
            @(posedge i_clk);
            drain_wait++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Run covered %0d polls: %0d page sends, %0d finished writes, %0d zero-length rejects",
                 board.polls, board.chunks, board.completions, board.rejects);
        $display("across %0d timeout settings incl. zero and all-ones, with a %0d-cycle output stall",
                 board.settings, SQUEEZE_LEN);
        if (board.queued_results.size() == 0 && board.mismatches == 0 && board.strays == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("ERROR: %0d mismatches, %0d unexpected results, %0d results missing",
                     board.mismatches, board.strays, board.queued_results.size());
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### sim.f
design/epws_pkg.sv
design/epws_core.sv
design/eeprom_paged_write_sequencer.sv
test/tb_top.sv
